// ===== design/tri_tess_pkg.sv =====
// ----------------------------------------------------------------------------
// tri_tess_pkg
// Shared types and constants for the triangle tessellator.
// ----------------------------------------------------------------------------
package tri_tess_pkg;

    // coordinate format: signed fixed point, fixed by the word layout
    localparam int COORD_WIDTH = 16;
    // extra fraction bits carried by the step vectors
    localparam int FRAC        = 8;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int MAG_W       = COORD_WIDTH + FRAC;
    localparam int STEP_W      = MAG_W + 1;
    // divider: quotient bits retired per cycle
    localparam int DIV_BITS    = 4;
    localparam int DIV_STEPS   = MAG_W / DIV_BITS;
    // two step vectors of three axes each
    localparam int NUM_DIV     = 6;

    localparam int CFG_W       = 3;
    localparam int APB_AW      = 2;
    localparam int APB_DW      = 32;
    localparam logic [APB_AW-1:0] ADDR_SUBDIV = 2'd0;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vertex;

    typedef struct packed {
        t_coord corner_a_x;
        t_coord corner_a_y;
        t_coord corner_a_z;
        t_coord corner_b_x;
        t_coord corner_b_y;
        t_coord corner_b_z;
        t_coord corner_c_x;
        t_coord corner_c_y;
        t_coord corner_c_z;
    } t_in_word;

    typedef struct packed {
        t_coord vert0_x;
        t_coord vert0_y;
        t_coord vert0_z;
        t_coord vert1_x;
        t_coord vert1_y;
        t_coord vert1_z;
        t_coord vert2_x;
        t_coord vert2_y;
        t_coord vert2_z;
        logic   last_of_run;
    } t_out_word;

endpackage

// ===== design/triangle_tessellator.sv =====
// ----------------------------------------------------------------------------
// triangle_tessellator
// Uniform subdivision of one triangle into (n+1)^2 sub-triangles.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                   word
//  --------  ---------  --------------------------  -----------------------
//  in        input      i_in_valid / o_in_stall     t_in_word, corners a,b,c
//  out       output     o_out_valid / i_out_stall   t_out_word, one triangle
//  config    input      psel/penable/pwrite/pready  subdivision_count @ 0x0
//
//  Per input word: the idle state takes it, then the serial divider works
//  out the step vectors one axis at a time (S_DLD, then S_DIV with 4
//  quotient bits per cycle), then each row runs the setup states S_BL and
//  S_TL before S_UP/S_DN emit its triangles; the emit states wait while out
//  stalls.
//  Reset (i_rst_n low, synchronous) returns to idle and clears the count.
//  o_in_stall is high from acceptance until the last triangle is loaded into
//  the output register; a stalled output only holds the sequencer in place.
//
module triangle_tessellator
    import tri_tess_pkg::*;
#(
    parameter int MAX_SUBDIVISION = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_word,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_word,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // lattice index width: must hold MAX_SUBDIVISION + 1 (also the divisor)
    localparam int IDX_W  = $clog2(MAX_SUBDIVISION + 2);
    localparam int PROD_W = STEP_W + IDX_W + 1;
    localparam int OFF_W  = PROD_W + 1;
    localparam int SUM_W  = OFF_W - FRAC + 1;
    localparam int K_W    = $clog2(NUM_DIV);
    localparam int DC_W   = $clog2(DIV_STEPS);

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a word
    localparam logic [2:0] S_DLD  = 3'd1;  // load one dividend
    localparam logic [2:0] S_DIV  = 3'd2;  // serial division
    localparam logic [2:0] S_BL   = 3'd3;  // row start: V(i,j)
    localparam logic [2:0] S_TL   = 3'd4;  // row start: V(i,j+1)
    localparam logic [2:0] S_UP   = 3'd5;  // upright triangle, new V(i+1,j)
    localparam logic [2:0] S_DN   = 3'd6;  // inverted triangle, new V(i+1,j+1)

    logic [2:0]                r_state, n_state;
    logic [CFG_W-1:0]          r_cfg;
    t_coord                    r_base [3];
    logic signed [DIFF_W-1:0]  r_diff [NUM_DIV];   // b-a (0..2), c-a (3..5)
    logic signed [STEP_W-1:0]  r_step [NUM_DIV];   // u (0..2), v (3..5)
    logic [K_W-1:0]            r_k, n_k;
    logic [DC_W-1:0]           r_dcnt, n_dcnt;
    logic [MAG_W-1:0]          r_dq;               // dividend in, quotient out
    logic [IDX_W-1:0]          r_rem;
    logic                      r_neg;
    logic [IDX_W-1:0]          r_col, n_col;
    logic [IDX_W-1:0]          r_row, n_row;
    // sliding window of lattice vertices: bottom-left, top-left, bottom-right
    t_vertex                   r_bl, r_tl, r_br;
    logic                      r_out_vld;
    t_out_word                 r_out;

    logic                      w_in_acc;
    logic                      w_cfg_wr;
    logic                      w_out_free;
    logic [IDX_W-1:0]          w_n;
    logic [IDX_W-1:0]          w_div;
    logic [IDX_W-1:0]          w_row_max;
    logic                      w_emit;
    logic                      w_last;
    t_out_word                 w_tri;

    // ------------------------------------------------------------------------
    // handshakes and config
    // ------------------------------------------------------------------------
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !r_out_vld || !i_out_stall;

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == ADDR_SUBDIV);
    assign prdata   = (paddr == ADDR_SUBDIV) ? APB_DW'(r_cfg) : '0;

    // counts above the build limit clamp to it
    assign w_n       = (32'(r_cfg) > MAX_SUBDIVISION) ? IDX_W'(MAX_SUBDIVISION)
                                                      : IDX_W'(r_cfg);
    assign w_div     = w_n + IDX_W'(1);
    assign w_row_max = w_n - r_row;

    // ------------------------------------------------------------------------
    // divider: restoring, DIV_BITS quotient bits per cycle, magnitude only;
    // sign reapplied at the end, so the step truncates toward zero
    // ------------------------------------------------------------------------
    logic signed [DIFF_W-1:0]  w_d;
    logic signed [DIFF_W-1:0]  w_mag;
    logic [IDX_W-1:0]          w_rem_nx;
    logic [DIV_BITS-1:0]       w_qbits;
    logic [MAG_W-1:0]          w_quot;
    logic signed [STEP_W-1:0]  w_step_pos;
    logic signed [STEP_W-1:0]  w_step;

    assign w_d   = r_diff[r_k];
    assign w_mag = w_d[DIFF_W-1] ? -w_d : w_d;

    always_comb begin : div_unit
        logic [IDX_W:0]   t;
        logic [IDX_W-1:0] rem;
        rem     = r_rem;
        w_qbits = '0;
        for (int b = 0; b < DIV_BITS; b++) begin
            t = {rem, r_dq[MAG_W-1-b]};
            if (t >= {1'b0, w_div}) begin
                w_qbits[DIV_BITS-1-b] = 1'b1;
                t = t - {1'b0, w_div};
            end
            rem = t[IDX_W-1:0];
        end
        w_rem_nx = rem;
    end

    assign w_quot     = {r_dq[MAG_W-DIV_BITS-1:0], w_qbits};
    assign w_step_pos = signed'({1'b0, w_quot});
    assign w_step     = r_neg ? -w_step_pos : w_step_pos;

    // ------------------------------------------------------------------------
    // vertex unit: one lattice vertex, all three axes, per cycle
    // V = a + floor((u*i + v*j) / 256), saturated
    // ------------------------------------------------------------------------
    logic [IDX_W-1:0] w_vi, w_vj;
    t_coord           w_vc [3];
    t_vertex          w_vtx;

    always_comb begin
        unique case (r_state)
            S_TL: begin
                w_vi = r_col;
                w_vj = r_row + IDX_W'(1);
            end
            S_UP: begin
                w_vi = r_col + IDX_W'(1);
                w_vj = r_row;
            end
            S_DN: begin
                w_vi = r_col + IDX_W'(1);
                w_vj = r_row + IDX_W'(1);
            end
            default: begin
                w_vi = r_col;
                w_vj = r_row;
            end
        endcase
    end

    always_comb begin : vtx_unit
        logic signed [IDX_W:0]   vi_s;
        logic signed [IDX_W:0]   vj_s;
        logic signed [PROD_W-1:0] pu;
        logic signed [PROD_W-1:0] pv;
        logic signed [OFF_W-1:0]  off;
        logic signed [SUM_W-1:0]  sum;
        vi_s = signed'({1'b0, w_vi});
        vj_s = signed'({1'b0, w_vj});
        for (int ax = 0; ax < 3; ax++) begin
            pu  = r_step[ax] * vi_s;
            pv  = r_step[ax+3] * vj_s;
            off = OFF_W'(pu) + OFF_W'(pv);
            // arithmetic drop of the fraction is the floor
            sum = SUM_W'(signed'(off[OFF_W-1:FRAC])) + SUM_W'(r_base[ax]);
            if (sum[SUM_W-1:COORD_WIDTH-1] == '0 || sum[SUM_W-1:COORD_WIDTH-1] == '1) begin
                w_vc[ax] = sum[COORD_WIDTH-1:0];
            end else if (sum[SUM_W-1]) begin
                w_vc[ax] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
            end else begin
                w_vc[ax] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
            end
        end
    end

    assign w_vtx = '{x: w_vc[0], y: w_vc[1], z: w_vc[2]};

    // ------------------------------------------------------------------------
    // sequencer
    // Row walk: BL, TL, then UP/DN alternate; each UP or DN needs only one
    // new vertex since the window slides right after every DN.
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_row   = r_row;
        n_k     = r_k;
        n_dcnt  = r_dcnt;
        w_emit  = 1'b0;
        w_last  = 1'b0;
        w_tri   = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_DLD;
                    n_k     = '0;
                end
            end
            S_DLD: begin
                n_state = S_DIV;
                n_dcnt  = '0;
            end
            S_DIV: begin
                n_dcnt = r_dcnt + DC_W'(1);
                if (r_dcnt == DC_W'(DIV_STEPS - 1)) begin
                    if (r_k == K_W'(NUM_DIV - 1)) begin
                        n_state = S_BL;
                        n_col   = '0;
                        n_row   = '0;
                    end else begin
                        n_k     = r_k + K_W'(1);
                        n_state = S_DLD;
                    end
                end
            end
            S_BL: n_state = S_TL;
            S_TL: n_state = S_UP;
            S_UP: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    // the last row holds a single upright triangle
                    w_last = (r_row == w_n);
                    w_tri  = t_out_word'({r_bl, r_tl, w_vtx, w_last});
                    if (r_col < w_row_max) begin
                        n_state = S_DN;
                    end else if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_row   = r_row + IDX_W'(1);
                        n_col   = '0;
                        n_state = S_BL;
                    end
                end
            end
            S_DN: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    w_tri   = t_out_word'({r_tl, w_vtx, r_br, 1'b0});
                    n_col   = r_col + IDX_W'(1);
                    n_state = S_UP;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg     <= '0;
            r_out_vld <= 1'b0;
            r_k       <= '0;
            r_dcnt    <= '0;
            r_col     <= '0;
            r_row     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_dcnt  <= n_dcnt;
            r_col   <= n_col;
            r_row   <= n_row;
            if (w_cfg_wr) begin
                r_cfg <= pwdata[CFG_W-1:0];
            end
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_base[0] <= i_in_word.corner_a_x;
            r_base[1] <= i_in_word.corner_a_y;
            r_base[2] <= i_in_word.corner_a_z;
            r_diff[0] <= DIFF_W'(i_in_word.corner_b_x) - DIFF_W'(i_in_word.corner_a_x);
            r_diff[1] <= DIFF_W'(i_in_word.corner_b_y) - DIFF_W'(i_in_word.corner_a_y);
            r_diff[2] <= DIFF_W'(i_in_word.corner_b_z) - DIFF_W'(i_in_word.corner_a_z);
            r_diff[3] <= DIFF_W'(i_in_word.corner_c_x) - DIFF_W'(i_in_word.corner_a_x);
            r_diff[4] <= DIFF_W'(i_in_word.corner_c_y) - DIFF_W'(i_in_word.corner_a_y);
            r_diff[5] <= DIFF_W'(i_in_word.corner_c_z) - DIFF_W'(i_in_word.corner_a_z);
        end
        if (r_state == S_DLD) begin
            r_dq  <= {w_mag[COORD_WIDTH-1:0], {FRAC{1'b0}}};
            r_rem <= '0;
            r_neg <= w_d[DIFF_W-1];
        end
        if (r_state == S_DIV) begin
            r_dq  <= w_quot;
            r_rem <= w_rem_nx;
            if (r_dcnt == DC_W'(DIV_STEPS - 1)) begin
                r_step[r_k] <= w_step;
            end
        end
        if (r_state == S_BL) begin
            r_bl <= w_vtx;
        end
        if (r_state == S_TL) begin
            r_tl <= w_vtx;
        end
        if (r_state == S_UP && w_emit) begin
            r_br <= w_vtx;
        end
        if (r_state == S_DN && w_emit) begin
            r_bl <= r_br;
            r_tl <= w_vtx;
        end
        if (w_emit) begin
            r_out <= w_tri;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_DLD))
        else $error("accepted word did not start the divider");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < w_div))
        else $error("divider remainder not below divisor");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last) |=> (r_state == S_IDLE))
        else $error("run continued after last triangle");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BL || r_state == S_TL || r_state == S_UP || r_state == S_DN)
        |-> (r_row <= w_n) && (r_col <= w_row_max))
        else $error("lattice walk left the triangle");

endmodule
